// ===== hdl/fscc_pkg.sv =====
`default_nettype none

package fscc_pkg;

	// defaults for the top-level parameters
	localparam int DEF_NUM_CONDITIONS = 8;
	localparam int DEF_MAX_IMPLICANTS = 4;
	localparam int DEF_VALUE_BITS     = 16;

	// fixed field widths
	localparam int COND_PORTS = 8;
	localparam int IN_W       = 16;
	localparam int CODE_W     = 4;
	localparam int WORD_W     = 32;
	localparam int NUM_WORDS  = 4;
	localparam int CNT_W      = 3;
	localparam int MASK_W     = 8;
	localparam int THR_W      = 16;
	localparam int SUM_W      = 32;
	localparam int PROD_W     = SUM_W + THR_W;
	localparam int FLAG_BITS  = 3;

	localparam int S_TDATA_W  = ((COND_PORTS + 1) * IN_W + 7) / 8 * 8;
	localparam int M_TDATA_W  = (FLAG_BITS + 3 * SUM_W + 7) / 8 * 8;

	// register indexes
	localparam int CFG_ADDR_W = 3;
	localparam logic [CFG_ADDR_W-1:0] REG_IMPL_0     = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_IMPL_1     = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_IMPL_2     = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_IMPL_3     = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_IMPL_COUNT = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_FUZZY_MASK = 3'd5;
	localparam logic [CFG_ADDR_W-1:0] REG_CONS_THR   = 3'd6;
	localparam logic [CFG_ADDR_W-1:0] REG_COV_THR    = 3'd7;

	// register reset values
	localparam logic [CNT_W-1:0] RST_IMPL_COUNT = 3'd1;
	localparam logic [THR_W-1:0] RST_CONS_THR   = 16'hFFFF;
	localparam logic [THR_W-1:0] RST_COV_THR    = 16'h0000;

	// per-condition codes
	localparam logic [CODE_W-1:0] CODE_ABSENT    = 4'd0;
	localparam logic [CODE_W-1:0] CODE_WANT_ZERO = 4'd1;

	typedef logic [COND_PORTS-1:0][IN_W-1:0] cond_vec_t;

	// load enables for the ratio check stages
	typedef struct packed {
		logic ld_s4;
		logic ld_s5;
	} check_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/fscc_lane.sv =====
`default_nettype none

// One implicant: minimum over the condition terms.
module fscc_lane #(
	parameter int NUM_CONDITIONS = fscc_pkg::DEF_NUM_CONDITIONS,
	parameter int VALUE_BITS     = fscc_pkg::DEF_VALUE_BITS
) (
	input  fscc_pkg::cond_vec_t                   cond,
	input  logic [fscc_pkg::WORD_W-1:0]           word,
	input  logic [fscc_pkg::MASK_W-1:0]           fuzzy,
	output logic [VALUE_BITS-1:0]                 memb
);

	localparam logic [VALUE_BITS-1:0]     ONE    = '1;
	localparam logic [fscc_pkg::IN_W-1:0] ONE_IN = fscc_pkg::IN_W'(ONE);

	logic [fscc_pkg::CODE_W-1:0] code;
	logic [VALUE_BITS-1:0]       v;
	logic [VALUE_BITS-1:0]       term;
	logic [VALUE_BITS-1:0]       m;

	always_comb begin
		m    = ONE;
		code = fscc_pkg::CODE_ABSENT;
		v    = '0;
		term = '0;
		for (int c = 0; c < NUM_CONDITIONS; c++) begin
			code = word[c*fscc_pkg::CODE_W +: fscc_pkg::CODE_W];
			if (fuzzy[c]) begin
				v    = (cond[c] > ONE_IN) ? ONE : cond[c][VALUE_BITS-1:0];
				term = (code == fscc_pkg::CODE_WANT_ZERO) ? ONE - v : v;
			end else begin
				term = (cond[c] == fscc_pkg::IN_W'(code - fscc_pkg::CODE_WANT_ZERO)) ?
					ONE : '0;
			end
			if (code != fscc_pkg::CODE_ABSENT && term < m)
				m = term;
		end
		memb = m;
	end

endmodule

`default_nettype wire

// ===== hdl/fscc_merge.sv =====
`default_nettype none

// Max over the used lanes, then overlap with the outcome.
module fscc_merge #(
	parameter int MAX_IMPLICANTS = fscc_pkg::DEF_MAX_IMPLICANTS,
	parameter int VALUE_BITS     = fscc_pkg::DEF_VALUE_BITS
) (
	input  logic [MAX_IMPLICANTS-1:0][VALUE_BITS-1:0] memb,
	input  logic [fscc_pkg::CNT_W-1:0]                count,
	input  logic [VALUE_BITS-1:0]                     outcome,
	output logic [VALUE_BITS-1:0]                     sol,
	output logic [VALUE_BITS-1:0]                     overlap
);

	always_comb begin
		sol = '0;
		// count above the lane count just enables every lane
		for (int i = 0; i < MAX_IMPLICANTS; i++) begin
			if (fscc_pkg::CNT_W'(i) < count && memb[i] > sol)
				sol = memb[i];
		end
		overlap = (sol < outcome) ? sol : outcome;
	end

endmodule

`default_nettype wire

// ===== hdl/fscc_check.sv =====
`default_nettype none

// Cross-multiplied ratio checks: products in s4, compares in s5.
module fscc_check #(
	parameter int VALUE_BITS = fscc_pkg::DEF_VALUE_BITS
) (
	input  logic                         clk,
	input  fscc_pkg::check_ctl_t         ctl,
	input  logic [fscc_pkg::SUM_W-1:0]   tot_sol,
	input  logic [fscc_pkg::SUM_W-1:0]   tot_ov,
	input  logic [fscc_pkg::SUM_W-1:0]   tot_out,
	input  logic [fscc_pkg::THR_W-1:0]   thr_cons,
	input  logic [fscc_pkg::THR_W-1:0]   thr_cov,
	output logic                         consistency_ok_q,
	output logic                         coverage_ok_q,
	output logic                         solution_ok_q,
	output logic [fscc_pkg::SUM_W-1:0]   total_solution_q,
	output logic [fscc_pkg::SUM_W-1:0]   total_overlap_q,
	output logic [fscc_pkg::SUM_W-1:0]   total_outcome_q
);

	localparam logic [VALUE_BITS-1:0]       ONE   = '1;
	localparam logic [fscc_pkg::PROD_W-1:0] ONE_P = fscc_pkg::PROD_W'(ONE);

	logic [fscc_pkg::PROD_W-1:0] p_num_s4;
	logic [fscc_pkg::PROD_W-1:0] p_cons_s4;
	logic [fscc_pkg::PROD_W-1:0] p_cov_s4;
	logic                        sol_nz_s4;
	logic                        out_nz_s4;
	logic [fscc_pkg::SUM_W-1:0]  tot_sol_s4;
	logic [fscc_pkg::SUM_W-1:0]  tot_ov_s4;
	logic [fscc_pkg::SUM_W-1:0]  tot_out_s4;
	logic                        cons;
	logic                        cov;

	always_ff @(posedge clk) begin
		if (ctl.ld_s4) begin
			p_num_s4   <= fscc_pkg::PROD_W'(tot_ov) * ONE_P;
			p_cons_s4  <= fscc_pkg::PROD_W'(thr_cons) * fscc_pkg::PROD_W'(tot_sol);
			p_cov_s4   <= fscc_pkg::PROD_W'(thr_cov) * fscc_pkg::PROD_W'(tot_out);
			sol_nz_s4  <= (tot_sol != '0);
			out_nz_s4  <= (tot_out != '0);
			tot_sol_s4 <= tot_sol;
			tot_ov_s4  <= tot_ov;
			tot_out_s4 <= tot_out;
		end
	end

	assign cons = sol_nz_s4 && (p_num_s4 >= p_cons_s4);
	assign cov  = out_nz_s4 && (p_num_s4 >= p_cov_s4);

	always_ff @(posedge clk) begin
		if (ctl.ld_s5) begin
			consistency_ok_q <= cons;
			coverage_ok_q    <= cov;
			solution_ok_q    <= cons && cov;
			total_solution_q <= tot_sol_s4;
			total_overlap_q  <= tot_ov_s4;
			total_outcome_q  <= tot_out_s4;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/fuzzy_solution_consistency_check_core.sv =====
// A last row passes through s1, s2, s3, s4 and s5 before its result shows on m_tdata.
// Throughput: one row per cycle; rows keep flowing while a result waits, and the
// input stalls only when a further last row finds the result stages (s3..s5) full.
// Reset (arst_n low, asynchronous): registers return to their reset values,
// sums clear to zero, all pipeline stages empty.
`default_nettype none

module fuzzy_solution_consistency_check_core #(
	parameter int NUM_CONDITIONS = fscc_pkg::DEF_NUM_CONDITIONS,
	parameter int MAX_IMPLICANTS = fscc_pkg::DEF_MAX_IMPLICANTS,
	parameter int VALUE_BITS     = fscc_pkg::DEF_VALUE_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,

	// slave: one data row per item
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// cond_a [15:0] .. cond_h [127:112], outcome_value [143:128]
	input  logic [fscc_pkg::S_TDATA_W-1:0]     s_tdata,
	input  logic                               s_tlast,   // last_row

	// master: one result per data set
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// consistency_ok [0], coverage_ok [1], solution_ok [2], total_solution [34:3],
	// total_overlap [66:35], total_outcome [98:67], zeros above
	output logic [fscc_pkg::M_TDATA_W-1:0]     m_tdata,

	// configuration writes
	input  logic                               cfg_we,
	input  logic [fscc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [fscc_pkg::WORD_W-1:0]        cfg_data
);

	localparam logic [VALUE_BITS-1:0]     ONE    = '1;
	localparam logic [fscc_pkg::IN_W-1:0] ONE_IN = fscc_pkg::IN_W'(ONE);

	function automatic logic [fscc_pkg::SUM_W-1:0] sat_add(
		input logic [fscc_pkg::SUM_W-1:0] a,
		input logic [VALUE_BITS-1:0]      b
	);
		logic [fscc_pkg::SUM_W:0] s;
		s = {1'b0, a} + (fscc_pkg::SUM_W+1)'(b);
		return s[fscc_pkg::SUM_W] ? '1 : s[fscc_pkg::SUM_W-1:0];
	endfunction

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [fscc_pkg::NUM_WORDS-1:0][fscc_pkg::WORD_W-1:0] word_q;
	logic [fscc_pkg::CNT_W-1:0]  count_q;
	logic [fscc_pkg::MASK_W-1:0] mask_q;
	logic [fscc_pkg::THR_W-1:0]  thr_cons_q;
	logic [fscc_pkg::THR_W-1:0]  thr_cov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q     <= '0;
			count_q    <= fscc_pkg::RST_IMPL_COUNT;
			mask_q     <= '0;
			thr_cons_q <= fscc_pkg::RST_CONS_THR;
			thr_cov_q  <= fscc_pkg::RST_COV_THR;
		end else if (cfg_we) begin
			case (cfg_addr)
				fscc_pkg::REG_IMPL_0:     word_q[0]  <= cfg_data;
				fscc_pkg::REG_IMPL_1:     word_q[1]  <= cfg_data;
				fscc_pkg::REG_IMPL_2:     word_q[2]  <= cfg_data;
				fscc_pkg::REG_IMPL_3:     word_q[3]  <= cfg_data;
				fscc_pkg::REG_IMPL_COUNT: count_q    <= cfg_data[fscc_pkg::CNT_W-1:0];
				fscc_pkg::REG_FUZZY_MASK: mask_q     <= cfg_data[fscc_pkg::MASK_W-1:0];
				fscc_pkg::REG_CONS_THR:   thr_cons_q <= cfg_data[fscc_pkg::THR_W-1:0];
				fscc_pkg::REG_COV_THR:    thr_cov_q  <= cfg_data[fscc_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Flow control. Rows occupy s1/s2; only last rows create an item in
	// s3 (totals), s4 (products) and s5 (output register). A non-last row
	// in s2 always drains into the sums.
	// ---------------------------------------------------------------
	logic v1_q, v2_q, v3_q, v4_q, v5_q;
	logic last_s1, last_s2;
	logic ready1, ready2, ready3, ready4, ready5;
	logic adv2;

	assign ready5   = !v5_q || m_tready;
	assign ready4   = !v4_q || ready5;
	assign ready3   = !v3_q || ready4;
	assign adv2     = v2_q && (!last_s2 || ready3);
	assign ready2   = !v2_q || adv2;
	assign ready1   = !v1_q || ready2;
	assign s_tready = ready1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			v5_q <= 1'b0;
		end else begin
			if (ready1) v1_q <= s_tvalid;
			if (ready2) v2_q <= v1_q;
			if (adv2 && last_s2) v3_q <= 1'b1;
			else if (ready4)     v3_q <= 1'b0;
			if (ready4) v4_q <= v3_q;
			if (ready5) v5_q <= v4_q;
		end
	end

	// ---------------------------------------------------------------
	// s1: implicant lanes work in parallel on the incoming row
	// ---------------------------------------------------------------
	fscc_pkg::cond_vec_t                         cond_in;
	logic [fscc_pkg::IN_W-1:0]                   outcome_in;
	logic [MAX_IMPLICANTS-1:0][VALUE_BITS-1:0]   memb;
	logic [MAX_IMPLICANTS-1:0][VALUE_BITS-1:0]   memb_s1;
	logic [VALUE_BITS-1:0]                       outc_s1;

	assign cond_in    = s_tdata[fscc_pkg::COND_PORTS*fscc_pkg::IN_W-1:0];
	assign outcome_in = s_tdata[fscc_pkg::COND_PORTS*fscc_pkg::IN_W +: fscc_pkg::IN_W];

	for (genvar i = 0; i < MAX_IMPLICANTS; i++) begin : g_lane
		fscc_lane #(
			.NUM_CONDITIONS (NUM_CONDITIONS),
			.VALUE_BITS     (VALUE_BITS)
		) u_lane (
			.cond  (cond_in),
			.word  (word_q[i]),
			.fuzzy (mask_q),
			.memb  (memb[i])
		);
	end

	always_ff @(posedge clk) begin
		if (ready1) begin
			memb_s1 <= memb;
			// outcome above one saturates to one
			outc_s1 <= (outcome_in > ONE_IN) ? ONE : outcome_in[VALUE_BITS-1:0];
			last_s1 <= s_tlast;
		end
	end

	// ---------------------------------------------------------------
	// s2: merge lanes into solution membership and overlap
	// ---------------------------------------------------------------
	logic [VALUE_BITS-1:0] sol;
	logic [VALUE_BITS-1:0] ovl;
	logic [VALUE_BITS-1:0] sol_s2;
	logic [VALUE_BITS-1:0] ovl_s2;
	logic [VALUE_BITS-1:0] outc_s2;

	fscc_merge #(
		.MAX_IMPLICANTS (MAX_IMPLICANTS),
		.VALUE_BITS     (VALUE_BITS)
	) u_merge (
		.memb    (memb_s1),
		.count   (count_q),
		.outcome (outc_s1),
		.sol     (sol),
		.overlap (ovl)
	);

	always_ff @(posedge clk) begin
		if (ready2) begin
			sol_s2  <= sol;
			ovl_s2  <= ovl;
			outc_s2 <= outc_s1;
			last_s2 <= last_s1;
		end
	end

	// ---------------------------------------------------------------
	// s3: saturating sums; a last row snapshots totals and clears them
	// ---------------------------------------------------------------
	logic [fscc_pkg::SUM_W-1:0] acc_sol_q, acc_ov_q, acc_out_q;
	logic [fscc_pkg::SUM_W-1:0] nxt_sol, nxt_ov, nxt_out;
	logic [fscc_pkg::SUM_W-1:0] tot_sol_s3, tot_ov_s3, tot_out_s3;

	assign nxt_sol = sat_add(acc_sol_q, sol_s2);
	assign nxt_ov  = sat_add(acc_ov_q, ovl_s2);
	assign nxt_out = sat_add(acc_out_q, outc_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_sol_q <= '0;
			acc_ov_q  <= '0;
			acc_out_q <= '0;
		end else if (adv2) begin
			if (last_s2) begin
				acc_sol_q <= '0;
				acc_ov_q  <= '0;
				acc_out_q <= '0;
			end else begin
				acc_sol_q <= nxt_sol;
				acc_ov_q  <= nxt_ov;
				acc_out_q <= nxt_out;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && last_s2) begin
			tot_sol_s3 <= nxt_sol;
			tot_ov_s3  <= nxt_ov;
			tot_out_s3 <= nxt_out;
		end
	end

	// ---------------------------------------------------------------
	// s4/s5: ratio checks and output register
	// ---------------------------------------------------------------
	fscc_pkg::check_ctl_t       chk_ctl;
	logic                       consistency_ok;
	logic                       coverage_ok;
	logic                       solution_ok;
	logic [fscc_pkg::SUM_W-1:0] total_solution;
	logic [fscc_pkg::SUM_W-1:0] total_overlap;
	logic [fscc_pkg::SUM_W-1:0] total_outcome;

	assign chk_ctl.ld_s4 = ready4;
	assign chk_ctl.ld_s5 = ready5;

	fscc_check #(
		.VALUE_BITS (VALUE_BITS)
	) u_check (
		.clk              (clk),
		.ctl              (chk_ctl),
		.tot_sol          (tot_sol_s3),
		.tot_ov           (tot_ov_s3),
		.tot_out          (tot_out_s3),
		.thr_cons         (thr_cons_q),
		.thr_cov          (thr_cov_q),
		.consistency_ok_q (consistency_ok),
		.coverage_ok_q    (coverage_ok),
		.solution_ok_q    (solution_ok),
		.total_solution_q (total_solution),
		.total_overlap_q  (total_overlap),
		.total_outcome_q  (total_outcome)
	);

	assign m_tvalid = v5_q;
	assign m_tdata  = fscc_pkg::M_TDATA_W'({total_outcome, total_overlap, total_solution,
		solution_ok, coverage_ok, consistency_ok});

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import fscc_pkg::*;

	localparam logic [IN_W-1:0] FULL_SCALE = '1;	// membership 1.0
	localparam int VERDICT_W       = FLAG_BITS + 3 * SUM_W;
	localparam int SETTLE_CYCLES   = 12;	// wait after draining, with margin over the result pipeline
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int RANDOM_ROWS     = 1500;

	// one data row as it travels on the slave side
	typedef struct packed {
		logic             last;
		logic [IN_W-1:0]  outcome;
		cond_vec_t        conds;
	} row_t;

	// one result, laid out as on m_tdata (consistency_ok in bit 0)
	typedef struct packed {
		logic [SUM_W-1:0] outcome_sum;
		logic [SUM_W-1:0] overlap_sum;
		logic [SUM_W-1:0] solution_sum;
		logic             both_ok;
		logic             coverage_ok;
		logic             consistency_ok;
	} verdict_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	logic [S_TDATA_W-1:0]    s_tdata = '0;	// cond_a .. cond_h, outcome_value
	logic                    s_tlast = 1'b0;	// last_row
	logic                    m_tvalid;
	logic                    m_tready = 1'b0;
	// consistency_ok, coverage_ok, solution_ok, total_solution, total_overlap,
	// total_outcome, zero padding
	logic [M_TDATA_W-1:0]    m_tdata;
	logic                    cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0]   cfg_addr = '0;
	logic [WORD_W-1:0]       cfg_data = '0;

	fuzzy_solution_consistency_check_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow of the solution registers, kept in step with every write
	logic [WORD_W-1:0] impl_word [NUM_WORDS];
	logic [CNT_W-1:0]  impl_count;
	logic [MASK_W-1:0] fuzzy_conds;
	logic [THR_W-1:0]  cons_thr;
	logic [THR_W-1:0]  cov_thr;

	// Running sums of the open data set
	logic [SUM_W-1:0]  sum_solution;
	logic [SUM_W-1:0]  sum_overlap;
	logic [SUM_W-1:0]  sum_outcome;

	row_t     pending_rows [$];	// rows not yet put on the bus
	verdict_t awaited_verdicts [$];	// results predicted, not yet seen
	row_t     row_on_bus;
	int       error_count = 0;
	int       burst_left = 0;
	int       gap_left = 0;
	int       idle_cycles = 0;
	logic [4:0]  ready_step = '0;
	logic [31:0] ready_pattern = '1;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Implicant membership: min over its present conditions, 1.0 when empty.
	// With 16-bit values a fuzzy input can never exceed 1.0, so no clamp.
	function automatic logic [IN_W-1:0] implicant_degree(logic [WORD_W-1:0] word,
			cond_vec_t conds);
		logic [IN_W-1:0]   degree;
		logic [IN_W-1:0]   term;
		logic [CODE_W-1:0] code;
		degree = FULL_SCALE;
		for (int c = 0; c < DEF_NUM_CONDITIONS; c++) begin
			code = word[CODE_W*c +: CODE_W];
			if (code != CODE_ABSENT) begin
				if (fuzzy_conds[c]) begin
					// wanted value zero means the complement of the membership
					term = (code == CODE_WANT_ZERO) ? FULL_SCALE - conds[c] : conds[c];
				end else begin
					// crisp: full match on the category code, else nothing
					term = (conds[c] == IN_W'(code) - 1'b1) ? FULL_SCALE : '0;
				end
				if (term < degree)
					degree = term;
			end
		end
		return degree;
	endfunction

	function automatic logic [SUM_W-1:0] add_clamped(logic [SUM_W-1:0] acc,
			logic [IN_W-1:0] value);
		logic [SUM_W:0] total;
		total = {1'b0, acc} + (SUM_W+1)'(value);
		return total[SUM_W] ? {SUM_W{1'b1}} : total[SUM_W-1:0];
	endfunction

	// num/den >= thr/1.0 by cross products; an empty denominator fails
	function automatic logic ratio_reaches(logic [SUM_W-1:0] num, logic [SUM_W-1:0] den,
			logic [THR_W-1:0] thr);
		if (den == '0)
			return 1'b0;
		return (64'(num) * 64'(FULL_SCALE)) >= (64'(thr) * 64'(den));
	endfunction

	// Fold one accepted row into the sums; a last row closes the data set
	function automatic void accumulate_row(row_t r);
		logic [IN_W-1:0] solution;
		logic [IN_W-1:0] degree;
		logic [IN_W-1:0] overlap;
		int              used;
		verdict_t        v;
		solution = '0;
		// counts above the implicant slots are clamped, zero means no solution
		used = (int'(impl_count) > DEF_MAX_IMPLICANTS) ? DEF_MAX_IMPLICANTS
			: int'(impl_count);
		for (int i = 0; i < used; i++) begin
			degree = implicant_degree(impl_word[i], r.conds);
			if (degree > solution)
				solution = degree;
		end
		overlap = (solution < r.outcome) ? solution : r.outcome;
		sum_solution = add_clamped(sum_solution, solution);
		sum_overlap  = add_clamped(sum_overlap, overlap);
		sum_outcome  = add_clamped(sum_outcome, r.outcome);
		if (r.last) begin
			v.consistency_ok = ratio_reaches(sum_overlap, sum_solution, cons_thr);
			v.coverage_ok    = ratio_reaches(sum_overlap, sum_outcome, cov_thr);
			v.both_ok        = v.consistency_ok & v.coverage_ok;
			v.solution_sum   = sum_solution;
			v.overlap_sum    = sum_overlap;
			v.outcome_sum    = sum_outcome;
			awaited_verdicts.push_back(v);
			sum_solution = '0;
			sum_overlap  = '0;
			sum_outcome  = '0;
		end
	endfunction

	// ------------------------------------------------------------------
	// Row driver: bursts of random length, random gaps between them
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : row_driver
		logic holding;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tlast  <= 1'b0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			holding = s_tvalid;
			if (s_tvalid && s_tready) begin
				accumulate_row(row_on_bus);
				holding = 1'b0;
			end
			if (!holding) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_rows.size() != 0) begin
					row_on_bus = pending_rows.pop_front();
					s_tdata  <= {row_on_bus.outcome, row_on_bus.conds};
					s_tlast  <= row_on_bus.last;
					s_tvalid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						// now and then a long run with no idling at all
						burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 200)
							: $urandom_range(0, 15);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor: own stall pattern, compares with the oldest prediction
	// ------------------------------------------------------------------
	function automatic void check_field(string name, logic [SUM_W-1:0] want,
			logic [SUM_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : result_monitor
		verdict_t got;
		verdict_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			ready_step    = '0;
			ready_pattern = '1;
		end else begin
			if (m_tvalid && m_tready) begin
				got = verdict_t'(m_tdata[VERDICT_W-1:0]);
				if (awaited_verdicts.size() == 0) begin
					$error("result with no data set pending: %h", m_tdata);
					error_count++;
				end else begin
					want = awaited_verdicts.pop_front();
					check_field("consistency_ok", SUM_W'(want.consistency_ok),
						SUM_W'(got.consistency_ok));
					check_field("coverage_ok", SUM_W'(want.coverage_ok),
						SUM_W'(got.coverage_ok));
					check_field("solution_ok", SUM_W'(want.both_ok), SUM_W'(got.both_ok));
					check_field("total_solution", want.solution_sum, got.solution_sum);
					check_field("total_overlap", want.overlap_sum, got.overlap_sum);
					check_field("total_outcome", want.outcome_sum, got.outcome_sum);
					check_field("padding", '0, SUM_W'(m_tdata[M_TDATA_W-1:VERDICT_W]));
				end
			end
			// new ready pattern each time ready_step wraps: always ready, random, sparse or dense
			if (ready_step == '0) begin
				case ($urandom_range(0, 3))
					0: ready_pattern = '1;
					1: ready_pattern = $urandom();
					2: ready_pattern = $urandom() & $urandom();
					default: ready_pattern = $urandom() | $urandom();
				endcase
			end
			m_tready <= ready_pattern[ready_step];
			ready_step = ready_step + 1'b1;
		end
	end

	// Nothing accepted on either side for too long: the block is stuck
	always @(posedge clk) begin : watchdog
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles = 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles++;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [WORD_W-1:0] value);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= value;
		case (idx)
			REG_IMPL_0, REG_IMPL_1, REG_IMPL_2, REG_IMPL_3: impl_word[idx[1:0]] = value;
			REG_IMPL_COUNT: impl_count  = value[CNT_W-1:0];
			REG_FUZZY_MASK: fuzzy_conds = value[MASK_W-1:0];
			REG_CONS_THR:   cons_thr    = value[THR_W-1:0];
			REG_COV_THR:    cov_thr     = value[THR_W-1:0];
			default: ;
		endcase
	endtask

	// Rewrites the whole solution; only called with the pipeline empty
	task automatic load_solution(logic [WORD_W-1:0] w0, logic [WORD_W-1:0] w1,
			logic [WORD_W-1:0] w2, logic [WORD_W-1:0] w3, logic [CNT_W-1:0] count,
			logic [MASK_W-1:0] mask, logic [THR_W-1:0] cthr, logic [THR_W-1:0] vthr);
		write_reg(REG_IMPL_0, w0);
		write_reg(REG_IMPL_1, w1);
		write_reg(REG_IMPL_2, w2);
		write_reg(REG_IMPL_3, w3);
		write_reg(REG_IMPL_COUNT, WORD_W'(count));
		write_reg(REG_FUZZY_MASK, WORD_W'(mask));
		write_reg(REG_CONS_THR, WORD_W'(cthr));
		write_reg(REG_COV_THR, WORD_W'(vthr));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until every row is in and every result is out, then let the
	// pipeline settle so no row is still in flight
	task automatic drain();
		while (pending_rows.size() != 0 || s_tvalid || awaited_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic void queue_row(cond_vec_t conds, logic [IN_W-1:0] outcome,
			logic last);
		row_t r;
		r.conds   = conds;
		r.outcome = outcome;
		r.last    = last;
		pending_rows.push_back(r);
	endfunction

	function automatic logic [WORD_W-1:0] random_word();
		logic [WORD_W-1:0] w;
		case ($urandom_range(0, 7))
			0: w = '0;	// empty implicant
			1: w = '1;	// every condition wants 14
			2: w = $urandom();
			default: begin
				// sparse implicants: a few present conditions keep the min alive
				w = '0;
				for (int c = 0; c < DEF_NUM_CONDITIONS; c++)
					if ($urandom_range(0, 99) < 35)
						w[CODE_W*c +: CODE_W] = CODE_W'($urandom_range(1, 15));
			end
		endcase
		return w;
	endfunction

	function automatic logic [THR_W-1:0] random_threshold();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return THR_W'($urandom());
			default: return THR_W'($urandom_range(16'h4000, 16'hF800));
		endcase
	endfunction

	// Row biased toward the configured codes so crisp terms actually match
	function automatic row_t random_row(logic last);
		row_t              r;
		logic [CODE_W-1:0] code;
		logic [WORD_W-1:0] word;
		for (int c = 0; c < DEF_NUM_CONDITIONS; c++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					word = impl_word[$urandom_range(0, NUM_WORDS - 1)];
					code = word[CODE_W*c +: CODE_W];
					r.conds[c] = (code == CODE_ABSENT) ? IN_W'($urandom_range(0, 15))
						: IN_W'(code) - 1'b1;
				end
				4, 5: r.conds[c] = IN_W'($urandom_range(0, 15));
				6: r.conds[c] = '0;
				7: r.conds[c] = '1;
				default: r.conds[c] = IN_W'($urandom());
			endcase
		end
		case ($urandom_range(0, 7))
			0: r.outcome = '0;
			1: r.outcome = '1;
			2, 3, 4: r.outcome = IN_W'($urandom_range(16'hC000, 16'hFFFF));
			default: r.outcome = IN_W'($urandom());
		endcase
		r.last = last;
		return r;
	endfunction

	initial begin : stimulus
		int                rows_left;
		int                set_len;
		logic [CNT_W-1:0]  count;
		logic [MASK_W-1:0] mask;

		// register and sum values after reset
		for (int i = 0; i < NUM_WORDS; i++)
			impl_word[i] = '0;
		impl_count   = RST_IMPL_COUNT;
		fuzzy_conds  = '0;
		cons_thr     = RST_CONS_THR;
		cov_thr      = RST_COV_THR;
		sum_solution = '0;
		sum_overlap  = '0;
		sum_outcome  = '0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset solution: one empty implicant, membership always 1.0
		queue_row('0, '0, 1'b1);	// no outcome: coverage has empty denominator
		queue_row('1, FULL_SCALE, 1'b1);
		drain();

		// complement, direct fuzzy, crisp code 15, code 1 on every condition; count clamps to 4
		load_solution(32'h0000_0001, 32'h0000_0020, 32'hF000_0000, 32'h1111_1111,
			3'd7, 8'h03, 16'h8000, 16'hFFFF);
		queue_row('0, FULL_SCALE, 1'b0);
		queue_row({16'd14, 80'h0, 16'hFFFF, 16'hFFFF}, 16'h1234, 1'b0);
		queue_row({16'd15, 80'h0, 16'h7FFF, 16'h8000}, 16'h9000, 1'b0);
		queue_row({8{16'h0001}}, '0, 1'b1);
		queue_row({16'd14, {7{16'hFFFF}}}, FULL_SCALE, 1'b1);
		queue_row({16'd0, 80'h0, 16'h0001, 16'hFFFE}, 16'h0001, 1'b1);
		drain();

		// no implicant in use: solution sum stays zero
		load_solution('1, '1, '1, '1, 3'd0, 8'hFF, 16'h0000, 16'h0000);
		queue_row('1, FULL_SCALE, 1'b1);
		queue_row('0, '0, 1'b1);
		drain();

		// crisp everywhere, wanted value 14 on every condition
		load_solution('1, '1, '1, '1, 3'd4, 8'h00, 16'hFFFF, 16'h0000);
		queue_row({8{16'd14}}, 16'h7FFF, 1'b0);
		queue_row({8{16'd14}}, FULL_SCALE, 1'b1);
		queue_row({8{16'd13}}, FULL_SCALE, 1'b1);
		drain();

		// random solutions, each followed by a handful of data sets
		rows_left = RANDOM_ROWS;
		while (rows_left > 0) begin
			case ($urandom_range(0, 5))
				0: count = 3'd0;
				1: count = CNT_W'($urandom_range(5, 7));
				default: count = CNT_W'($urandom_range(1, 4));
			endcase
			case ($urandom_range(0, 3))
				0: mask = '0;
				1: mask = '1;
				default: mask = MASK_W'($urandom());
			endcase
			load_solution(random_word(), random_word(), random_word(), random_word(),
				count, mask, random_threshold(), random_threshold());
			for (int s = $urandom_range(4, 16); s > 0; s--) begin
				set_len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40)
					: $urandom_range(1, 8);
				for (int k = 1; k <= set_len; k++)
					pending_rows.push_back(random_row(k == set_len));
				rows_left -= set_len;
			end
			drain();
		end

		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/fscc_pkg.sv
hdl/fscc_lane.sv
hdl/fscc_merge.sv
hdl/fscc_check.sv
hdl/fuzzy_solution_consistency_check_core.sv
sim/testbench.sv
